### design/script_language_lexer_unit_defines.svh
// Assertion macros for the lexer unit.
// No dependencies; included by modules that carry assertions.
`ifndef SCRIPT_LANGUAGE_LEXER_UNIT_DEFINES_SVH
`define SCRIPT_LANGUAGE_LEXER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SLL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLL_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLL_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### design/sll_pkg.sv
// Shared types, constants and keyword tables for the lexer unit.
// No dependencies.
package sll_pkg;
  localparam int OffsetBitsDef = 32;
  localparam int LengthBitsDef = 24;
  localparam int LineBitsDef   = 24;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [23:0] token_length;
    logic [23:0] line_number;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // byte class from the front end
  localparam logic [3:0] C_BLANK = 4'd0;
  localparam logic [3:0] C_NL    = 4'd1;
  localparam logic [3:0] C_PUNCT = 4'd2;
  localparam logic [3:0] C_SLASH = 4'd3;
  localparam logic [3:0] C_OPC   = 4'd4;
  localparam logic [3:0] C_QUOTE = 4'd5;
  localparam logic [3:0] C_LET   = 4'd6;
  localparam logic [3:0] C_DIG   = 4'd7;
  localparam logic [3:0] C_DOT   = 4'd8;
  localparam logic [3:0] C_BAD   = 4'd9;
  localparam logic [3:0] C_END   = 4'd10;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] cls;
    logic [5:0] kind1;   // single-char kind
    logic       is_eq;
  } cls_item_t;

  localparam logic [5:0] K_DOT = 6'd6;
  localparam logic [5:0] K_SLASH = 6'd9;
  localparam logic [5:0] K_IDENT = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_NUMBER = 6'd21;
  localparam logic [5:0] K_KW_BASE = 6'd22;
  localparam logic [5:0] K_ERROR = 6'd35;
  localparam logic [5:0] K_EOF = 6'd36;
  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_CHAR = 2'd1;
  localparam logic [1:0] E_STR  = 2'd2;
  localparam logic [5:0] KW_NONE = 6'd63;

  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_IDENT = 4'd1;
  localparam logic [3:0] M_NUM = 4'd2;
  localparam logic [3:0] M_NUM_DOT = 4'd3;
  localparam logic [3:0] M_STR = 4'd4;
  localparam logic [3:0] M_SLASH = 4'd5;
  localparam logic [3:0] M_OP2 = 4'd6;
  localparam logic [3:0] M_COMMENT = 4'd7;
  localparam logic [3:0] M_DONE = 4'd8;

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0: kw_len = 3'd3;  4'd1: kw_len = 3'd5;  4'd2: kw_len = 3'd4;
      4'd3: kw_len = 3'd5;  4'd4: kw_len = 3'd2;  4'd5: kw_len = 3'd3;
      4'd6: kw_len = 3'd2;  4'd7: kw_len = 3'd5;  4'd8: kw_len = 3'd6;
      4'd9: kw_len = 3'd5;  4'd10: kw_len = 3'd4; 4'd11: kw_len = 3'd3;
      4'd12: kw_len = 3'd5; default: kw_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [47:0] s;
    case (k)
      4'd0: s = "and";    4'd1: s = "class";  4'd2: s = "else";
      4'd3: s = "false";  4'd4: s = "if";     4'd5: s = "nil";
      4'd6: s = "or";     4'd7: s = "print";  4'd8: s = "return";
      4'd9: s = "super";  4'd10: s = "true";  4'd11: s = "var";
      4'd12: s = "while"; default: s = '0;
    endcase
    // strings are right-aligned; char p counted from the left of its length
    kw_char = (p < kw_len(k)) ?
      s[8*(kw_len(k) - 3'd1 - p) +: 8] : 8'd0;
  endfunction
endpackage

### design/script_language_lexer_unit.sv
// Top level of the lexer unit: front classifier, queue and back scanner.
// Depends on sll_pkg, sll_front, sll_queue and sll_back.
//
// Streaming lexical scanner. One source byte is a transfer on the in_
// channel; tokens leave as transfers on the out_ channel, each with kind,
// start offset, length, line and error code, last_of_run marking the final
// token caused by a byte. A byte that causes at most one token does not
// hold the back end, so plain source streams at one byte per clock while
// out_stall is low; a byte that releases more tokens (up to three, e.g.
// number, dot and a following operator) holds the back end while the
// output port drains the per-byte token buffer one token per cycle, as
// out_stall allows. A two-entry queue between the classifier and the
// scanner absorbs such bursts. Offsets, lengths and line numbers
// saturate at their widths. After end of input (end flag or a zero byte)
// every further byte yields the same end-of-file token until reset.
module script_language_lexer_unit #(
  parameter int OFFSET_BITS = sll_pkg::OffsetBitsDef,
  parameter int LENGTH_BITS = sll_pkg::LengthBitsDef,
  parameter int LINE_BITS   = sll_pkg::LineBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sll_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sll_pkg::out_item_t out_data
);
  logic               f_valid, f_stall, q_valid, q_stall;
  sll_pkg::cls_item_t f_data, q_data;

  sll_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .f_valid, .f_stall, .f_data
  );

  sll_queue u_queue (
    .clk, .rst_n, .w_valid(f_valid), .w_stall(f_stall), .w_data(f_data),
    .r_valid(q_valid), .r_stall(q_stall), .r_data(q_data)
  );

  sll_back #(
    .OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS), .LINE_BITS(LINE_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_data,
    .out_valid, .out_stall, .out_data
  );
endmodule

### design/sll_front.sv
// Front end: takes input bytes and classifies them into a small code.
// Depends on sll_pkg.
module sll_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sll_pkg::in_item_t  in_data,
  output logic               f_valid,
  input  logic               f_stall,
  output sll_pkg::cls_item_t f_data
);
  logic               v_r;
  sll_pkg::cls_item_t d_r;
  sll_pkg::cls_item_t c;
  logic [7:0]         ch;

  assign ch = in_data.char_in;
  always_comb begin
    c.ch = ch;
    c.kind1 = 6'd0;
    c.is_eq = (ch == "=");
    c.cls = sll_pkg::C_BAD;
    if (in_data.end_of_input || ch == 8'd0) c.cls = sll_pkg::C_END;
    else case (ch)
      " ", 8'd13, 8'd9: c.cls = sll_pkg::C_BLANK;
      8'd10: c.cls = sll_pkg::C_NL;
      "(": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd0; end
      ")": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd1; end
      "{": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd2; end
      "}": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd3; end
      ";": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd4; end
      ",": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd5; end
      "-": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd7; end
      "+": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd8; end
      "*": begin c.cls = sll_pkg::C_PUNCT; c.kind1 = 6'd10; end
      ".": begin c.cls = sll_pkg::C_DOT; c.kind1 = sll_pkg::K_DOT; end
      "/": c.cls = sll_pkg::C_SLASH;
      "!": begin c.cls = sll_pkg::C_OPC; c.kind1 = 6'd11; end
      "=": begin c.cls = sll_pkg::C_OPC; c.kind1 = 6'd13; end
      "<": begin c.cls = sll_pkg::C_OPC; c.kind1 = 6'd15; end
      ">": begin c.cls = sll_pkg::C_OPC; c.kind1 = 6'd17; end
      "\"": c.cls = sll_pkg::C_QUOTE;
      default: begin
        if (ch inside {["a":"z"], ["A":"Z"], "_"}) c.cls = sll_pkg::C_LET;
        else if (ch inside {["0":"9"]}) c.cls = sll_pkg::C_DIG;
      end
    endcase
  end

  assign in_stall = v_r && f_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (!in_stall) v_r <= in_valid;
    if (!in_stall && in_valid) d_r <= c;
  end
  assign f_valid = v_r;
  assign f_data  = d_r;
endmodule

### design/sll_queue.sv
// Two-entry queue between front and back ends.
// Depends on sll_pkg and the defines header.
`include "script_language_lexer_unit_defines.svh"
module sll_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               w_valid,
  output logic               w_stall,
  input  sll_pkg::cls_item_t w_data,
  output logic               r_valid,
  input  logic               r_stall,
  output sll_pkg::cls_item_t r_data
);
  sll_pkg::cls_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;
  assign w_stall = (cnt_r == 2'd2);
  assign r_valid = (cnt_r != 2'd0);
  assign r_data  = mem_r[rp_r];
  assign wr = w_valid && !w_stall;
  assign rd = r_valid && !r_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= w_data;
  end
  `SLL_ASSERT(a_q_cnt, clk, rst_n, cnt_r != 2'd3, "queue count out of range")
  `SLL_ASSERT(a_q_full, clk, rst_n, (cnt_r == 2'd2 && !rd) |=> cnt_r == 2'd2, "full queue drained without read")
  `SLL_ASSERT(a_q_ptr, clk, rst_n, (cnt_r == 2'd0) |-> (wp_r == rp_r), "empty queue pointers differ")
endmodule

### design/sll_back.sv
// Back end: scan FSM; emits up to three tokens per byte, one per unstalled cycle
// Depends on sll_pkg and the defines header.
`include "script_language_lexer_unit_defines.svh"
module sll_back #(
  parameter int OFFSET_BITS = sll_pkg::OffsetBitsDef,
  parameter int LENGTH_BITS = sll_pkg::LengthBitsDef,
  parameter int LINE_BITS   = sll_pkg::LineBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_stall,
  input  sll_pkg::cls_item_t q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sll_pkg::out_item_t out_data
);
  typedef struct packed {
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [1:0]             err;
  } tok_t;

  logic [3:0]             mode_r, mode_nxt;
  logic [5:0]             pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt, off_r, off_nxt, dot_r, dot_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [5:0]             kw_r, kw_nxt;
  logic                   frac_r, frac_nxt;

  // emission buffer: tokens of the current byte, drained one per cycle unless out_stall
  tok_t                 buf_r [4];
  tok_t                 tk [4];
  logic [LINE_BITS-1:0] bline_r;
  logic [2:0]           bcnt_r, bidx_r;
  logic [2:0]           n;

  logic                   take;
  logic [OFFSET_BITS-1:0] off_max;
  logic [LINE_BITS-1:0]   line_max;
  assign off_max = '1;
  assign line_max = '1;

  function automatic logic [LENGTH_BITS-1:0] linc(input logic [LENGTH_BITS-1:0] v);
    linc = (v == {LENGTH_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic tok_t mk(input logic [5:0] k, input logic [OFFSET_BITS-1:0] s,
                              input logic [LENGTH_BITS-1:0] l, input logic [1:0] e);
    mk.kind = k; mk.start = s; mk.len = l; mk.err = e;
  endfunction

  logic [5:0] word_kind;
  logic [3:0] kwi;
  logic [5:0] kw_adv;
  logic [2:0] kpos;
  logic [3:0] kfirst;
  logic       kfirst_hit;
  logic       c_let, c_dig;
  sll_pkg::cls_item_t d;

  assign d = q_data;
  assign c_let = (d.cls == sll_pkg::C_LET);
  assign c_dig = (d.cls == sll_pkg::C_DIG);
  assign kwi = kw_r[3:0] - 4'd1;

  always_comb begin
    word_kind = sll_pkg::K_IDENT;
    if (kw_r >= 6'd1 && kw_r <= 6'd13 &&
        len_r == LENGTH_BITS'(sll_pkg::kw_len(kwi)))
      word_kind = sll_pkg::K_KW_BASE + {2'b00, kwi};
  end

  // keyword prefix tracker for the next character of an identifier
  always_comb begin
    kpos = (len_r > LENGTH_BITS'(6)) ? 3'd7 : len_r[2:0];
    kw_adv = sll_pkg::KW_NONE;
    if (kw_r >= 6'd1 && kw_r <= 6'd13 && kpos < sll_pkg::kw_len(kwi) &&
        sll_pkg::kw_char(kwi, kpos) == d.ch)
      kw_adv = kw_r;
    if (kw_r == sll_pkg::KW_NONE) kw_adv = sll_pkg::KW_NONE;
    kfirst = 4'd0;
    kfirst_hit = 1'b0;
    for (int k = 0; k < 13; k++)
      if (sll_pkg::kw_char(4'(k), 3'd0) == d.ch) begin
        kfirst = 4'(k + 1); kfirst_hit = 1'b1;
      end
  end

  always_comb begin
    logic reidle;
    mode_nxt = mode_r; pend_nxt = pend_r; begin_nxt = begin_r; off_nxt = off_r;
    dot_nxt = dot_r; len_nxt = len_r; line_nxt = line_r; kw_nxt = kw_r;
    frac_nxt = frac_r; n = 3'd0; reidle = 1'b0;
    for (int i = 0; i < 4; i++) tk[i] = mk(6'd0, '0, '0, sll_pkg::E_NONE);
    if (mode_r == sll_pkg::M_DONE) begin
      tk[0] = mk(sll_pkg::K_EOF, off_r, '0, sll_pkg::E_NONE); n = 3'd1;
    end else if (d.cls == sll_pkg::C_END) begin
      case (mode_r)
        sll_pkg::M_IDENT: begin tk[0] = mk(word_kind, begin_r, len_r, 2'd0); n = 3'd1; end
        sll_pkg::M_NUM: begin tk[0] = mk(sll_pkg::K_NUMBER, begin_r, len_r, 2'd0); n = 3'd1; end
        sll_pkg::M_NUM_DOT: begin
          tk[0] = mk(sll_pkg::K_NUMBER, begin_r, len_r, 2'd0);
          tk[1] = mk(sll_pkg::K_DOT, dot_r, LENGTH_BITS'(1), 2'd0); n = 3'd2;
        end
        sll_pkg::M_STR: begin tk[0] = mk(sll_pkg::K_ERROR, begin_r, len_r, sll_pkg::E_STR); n = 3'd1; end
        sll_pkg::M_SLASH: begin tk[0] = mk(sll_pkg::K_SLASH, begin_r, LENGTH_BITS'(1), 2'd0); n = 3'd1; end
        sll_pkg::M_OP2: begin tk[0] = mk(pend_r, begin_r, LENGTH_BITS'(1), 2'd0); n = 3'd1; end
        default: ;
      endcase
      tk[n[1:0]] = mk(sll_pkg::K_EOF, off_r, '0, sll_pkg::E_NONE);
      n = n + 3'd1;
      mode_nxt = sll_pkg::M_DONE;
    end else begin
      case (mode_r)
        sll_pkg::M_IDENT:
          if (c_let || c_dig) begin kw_nxt = kw_adv; len_nxt = linc(len_r); end
          else begin tk[0] = mk(word_kind, begin_r, len_r, 2'd0); n = 3'd1; reidle = 1'b1; end
        sll_pkg::M_NUM:
          if (c_dig) len_nxt = linc(len_r);
          else if (d.cls == sll_pkg::C_DOT && !frac_r) begin
            dot_nxt = off_r; mode_nxt = sll_pkg::M_NUM_DOT;
          end else begin
            tk[0] = mk(sll_pkg::K_NUMBER, begin_r, len_r, 2'd0); n = 3'd1; reidle = 1'b1;
          end
        sll_pkg::M_NUM_DOT:
          if (c_dig) begin
            len_nxt = linc(linc(len_r)); frac_nxt = 1'b1; mode_nxt = sll_pkg::M_NUM;
          end else begin
            tk[0] = mk(sll_pkg::K_NUMBER, begin_r, len_r, 2'd0);
            tk[1] = mk(sll_pkg::K_DOT, dot_r, LENGTH_BITS'(1), 2'd0);
            n = 3'd2; reidle = 1'b1;
          end
        sll_pkg::M_STR: begin
          len_nxt = linc(len_r);
          if (d.cls == sll_pkg::C_QUOTE) begin
            tk[0] = mk(sll_pkg::K_STRING, begin_r, linc(len_r), 2'd0); n = 3'd1;
            mode_nxt = sll_pkg::M_IDLE;
          end else if (d.cls == sll_pkg::C_NL && line_r != line_max)
            line_nxt = line_r + 1'b1;
        end
        sll_pkg::M_SLASH:
          if (d.cls == sll_pkg::C_SLASH) mode_nxt = sll_pkg::M_COMMENT;
          else begin
            tk[0] = mk(sll_pkg::K_SLASH, begin_r, LENGTH_BITS'(1), 2'd0); n = 3'd1; reidle = 1'b1;
          end
        sll_pkg::M_OP2:
          if (d.is_eq) begin
            tk[0] = mk(pend_r + 6'd1, begin_r, LENGTH_BITS'(2), 2'd0); n = 3'd1;
            mode_nxt = sll_pkg::M_IDLE;
          end else begin
            tk[0] = mk(pend_r, begin_r, LENGTH_BITS'(1), 2'd0); n = 3'd1; reidle = 1'b1;
          end
        sll_pkg::M_COMMENT: if (d.cls == sll_pkg::C_NL) reidle = 1'b1;
        default: reidle = 1'b1;
      endcase
      if (reidle) begin
        mode_nxt = sll_pkg::M_IDLE;
        case (d.cls)
          sll_pkg::C_NL: if (line_r != line_max) line_nxt = line_r + 1'b1;
          sll_pkg::C_PUNCT, sll_pkg::C_DOT: begin
            tk[n[1:0]] = mk(d.kind1, off_r, LENGTH_BITS'(1), 2'd0); n = n + 3'd1;
          end
          sll_pkg::C_SLASH: begin
            begin_nxt = off_r; len_nxt = LENGTH_BITS'(1); mode_nxt = sll_pkg::M_SLASH;
          end
          sll_pkg::C_OPC: begin
            pend_nxt = d.kind1; begin_nxt = off_r; len_nxt = LENGTH_BITS'(1);
            mode_nxt = sll_pkg::M_OP2;
          end
          sll_pkg::C_QUOTE: begin
            begin_nxt = off_r; len_nxt = LENGTH_BITS'(1); mode_nxt = sll_pkg::M_STR;
          end
          sll_pkg::C_LET: begin
            begin_nxt = off_r; len_nxt = LENGTH_BITS'(1); mode_nxt = sll_pkg::M_IDENT;
            kw_nxt = kfirst_hit ? {2'b00, kfirst} : sll_pkg::KW_NONE;
          end
          sll_pkg::C_DIG: begin
            begin_nxt = off_r; len_nxt = LENGTH_BITS'(1); mode_nxt = sll_pkg::M_NUM;
            frac_nxt = 1'b0;
          end
          sll_pkg::C_BAD: begin
            tk[n[1:0]] = mk(sll_pkg::K_ERROR, off_r, LENGTH_BITS'(1), sll_pkg::E_CHAR);
            n = n + 3'd1;
          end
          default: ;
        endcase
      end
      if (off_r != off_max) off_nxt = off_r + 1'b1;
    end
  end

  // take a new byte when the buffer is empty or its last token leaves now
  logic last_go;
  assign out_valid = (bcnt_r != 3'd0);
  assign last_go = out_valid && !out_stall && (bidx_r + 3'd1 == bcnt_r);
  assign q_stall = !(bcnt_r == 3'd0 || last_go);
  assign take = q_valid && !q_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sll_pkg::M_IDLE; pend_r <= '0; begin_r <= '0; off_r <= '0;
      dot_r <= '0; len_r <= '0; line_r <= LINE_BITS'(1); kw_r <= '0; frac_r <= 1'b0;
      bcnt_r <= 3'd0; bidx_r <= 3'd0;
    end else begin
      if (take) begin
        mode_r <= mode_nxt; pend_r <= pend_nxt; begin_r <= begin_nxt; off_r <= off_nxt;
        dot_r <= dot_nxt; len_r <= len_nxt; line_r <= line_nxt; kw_r <= kw_nxt;
        frac_r <= frac_nxt; bcnt_r <= n; bidx_r <= 3'd0;
      end else if (last_go) begin
        bcnt_r <= 3'd0; bidx_r <= 3'd0;
      end else if (out_valid && !out_stall) bidx_r <= bidx_r + 3'd1;
    end
    // tokens carry the line count seen before this byte's newline, if any
    if (take) begin
      for (int i = 0; i < 4; i++) buf_r[i] <= tk[i];
      bline_r <= line_r;
    end
  end

  always_comb begin
    out_data.token_kind   = buf_r[bidx_r[1:0]].kind;
    out_data.token_start  = 32'(buf_r[bidx_r[1:0]].start);
    out_data.token_length = 24'(buf_r[bidx_r[1:0]].len);
    out_data.line_number  = 24'(bline_r);
    out_data.error_code   = buf_r[bidx_r[1:0]].err;
    out_data.last_of_run  = (bidx_r + 3'd1 == bcnt_r);
  end

  `SLL_ASSERT(a_b_cnt, clk, rst_n, bcnt_r <= 3'd4, "token count above four")
  `SLL_ASSERT(a_b_idx, clk, rst_n, out_valid |-> (bidx_r < bcnt_r), "token index past count")
  `SLL_ASSERT(a_b_done, clk, rst_n, (take && mode_r == sll_pkg::M_DONE) |=> (bcnt_r == 3'd1 && buf_r[0].kind == sll_pkg::K_EOF), "done state gave no single end token")
endmodule
